[design/ordered_queue_with_remove_by_value_core_defines.svh]
// ============================================================================
// Assertion macros for the ordered queue core
// Shared helpers that wrap concurrent assertions with a common reset guard.
// ============================================================================
`ifndef ORDERED_QUEUE_WITH_REMOVE_BY_VALUE_CORE_DEFINES_SVH
`define ORDERED_QUEUE_WITH_REMOVE_BY_VALUE_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define OQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication with the consequent checked in the following cycle.
`define OQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/oqrbv_pkg.sv]
// ============================================================================
// Ordered queue package
// Operation and status codes and default sizes.
// ============================================================================
package oqrbv_pkg;
    localparam int DefDepth      = 16;
    localparam int DefValueWidth = 32;
    localparam int KindW         = 3;
    localparam int StatusW       = 2;
    localparam int CountW        = 5;
    localparam int PortValueW    = 32;

    typedef enum logic [KindW-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_REMOVE    = 3'd2,
        KIND_POP       = 3'd3,
        KIND_MEMBER    = 3'd4
    } kind_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;
endpackage

[design/ordered_queue_with_remove_by_value_core.sv]
// ============================================================================
// Ordered queue with remove by value
// Sequence of handles held in one synchronous memory, walked entry by entry.
// ============================================================================
// One item is handled at a time. Insert back, pop on an empty queue, an
// insert into a full queue, a search of an empty queue and unused kinds go
// straight to the done state. Insert front shifts every entry one place
// back, one memory read and write per entry. Pop front shifts every entry
// one place forward. Membership walks from the front until a match; removal
// walks to the match and then shifts the tail forward, and takes longest
// when the last entry is removed. The single memory port pair (one read,
// one write per cycle) paces each walk and shift. The result is held in an
// output register; the next item is taken at the earliest in the cycle
// after the result has been accepted.
`include "ordered_queue_with_remove_by_value_core_defines.svh"

module ordered_queue_with_remove_by_value_core #(
    parameter int DEPTH       = oqrbv_pkg::DefDepth,
    parameter int VALUE_WIDTH = oqrbv_pkg::DefValueWidth
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [oqrbv_pkg::KindW-1:0]        kind,
    input  logic [oqrbv_pkg::PortValueW-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [oqrbv_pkg::StatusW-1:0]      status,
    output logic [oqrbv_pkg::PortValueW-1:0]   popped_value,
    output logic                               found,
    output logic [oqrbv_pkg::CountW-1:0]       count
);
    import oqrbv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SHIFT_FWD, S_SHIFT_BACK, S_DONE
    } state_t;

    // Entry memory with registered read data.
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t                 state_reg;
    kind_t                  kind_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          idx_reg;   // address read last cycle
    logic [VALUE_WIDTH-1:0] carry_reg; // value to write during back shift
    logic                   pend_reg;  // a read was issued last cycle
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [VALUE_WIDTH-1:0] popped_reg;
    logic                   found_reg;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    // Memory access control derived from the state.
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_valid && in_ready && kind == KIND_INS_BACK
                    && cnt_reg < CW'(DEPTH))
                begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[AW-1:0];
                    wr_data = VALUE_WIDTH'(value);
                end
            end
            S_SEARCH:
            begin
                rd_addr = AW'(idx_reg + 1'b1);
            end
            S_SHIFT_FWD:
            begin
                // Read idx+1 now; write it to idx once the data arrives.
                rd_addr = AW'(idx_reg + 1'b1);
                if (pend_reg && idx_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - 1'b1);
                end
            end
            S_SHIFT_BACK:
            begin
                rd_addr = AW'(idx_reg + 1'b1);
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = carry_reg;
                end
            end
            S_DONE:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // Sequencer, state and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_INS_FRONT;
            val_reg       <= '0;
            carry_reg     <= '0;
            status_reg    <= ST_OK;
            popped_reg    <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        kind_reg   <= kind_t'(kind);
                        val_reg    <= VALUE_WIDTH'(value);
                        status_reg <= ST_OK;
                        popped_reg <= '0;
                        found_reg  <= 1'b0;
                        idx_reg    <= '0;
                        pend_reg   <= 1'b0;
                        state_reg  <= S_DONE;
                        priority if (kind == KIND_INS_FRONT || kind == KIND_INS_BACK)
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                status_reg <= ST_FULL;
                            end
                            else if (kind == KIND_INS_BACK)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            else if (cnt_reg == '0)
                            begin
                                // Empty: the new value goes straight to the front.
                                carry_reg <= VALUE_WIDTH'(value);
                                pend_reg  <= 1'b1;
                                idx_reg   <= '0;
                                state_reg <= S_SHIFT_BACK;
                            end
                            else
                            begin
                                // Entry 0 is being read; it is carried back next.
                                carry_reg <= VALUE_WIDTH'(value);
                                pend_reg  <= 1'b1;
                                state_reg <= S_SHIFT_BACK;
                            end
                        end
                        else if (kind == KIND_POP)
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                // Entry 0 is being read; shift starts here.
                                pend_reg  <= 1'b1;
                                idx_reg   <= '0;
                                state_reg <= S_SHIFT_FWD;
                            end
                        end
                        else if (kind == KIND_REMOVE || kind == KIND_MEMBER)
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_reg <= S_SEARCH;
                            end
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // rd_data_reg holds entry idx.
                    if (rd_data_reg == val_reg)
                    begin
                        found_reg <= 1'b1;
                        if (kind_reg == KIND_MEMBER)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // Data of idx+1 arrives next cycle, to go to idx.
                            idx_reg   <= idx_reg + 1'b1;
                            pend_reg  <= 1'b1;
                            state_reg <= S_SHIFT_FWD;
                        end
                    end
                    else if (idx_reg >= cnt_reg - 1'b1)
                    begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SHIFT_FWD:
                begin
                    // Pop: first cycle captures entry 0 as the popped value.
                    if (kind_reg == KIND_POP && idx_reg == '0)
                    begin
                        popped_reg <= PortValueW'(rd_data_reg);
                    end
                    if (idx_reg >= cnt_reg - 1'b1)
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    idx_reg  <= idx_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                S_SHIFT_BACK:
                begin
                    // Write carry at idx, carry on with the old entry idx.
                    if (pend_reg)
                    begin
                        carry_reg <= rd_data_reg;
                        if (idx_reg >= cnt_reg)
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    pend_reg <= 1'b1;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign count        = CountW'(cnt_reg);

    `OQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(DEPTH))
    `OQ_ASSERT_IMPL(a_found_ok, clk, rst_n, out_valid_reg && found_reg, status_reg == ST_OK)
    `OQ_ASSERT_NEXT(a_done_to_out, clk, rst_n, state_reg == S_DONE, out_valid_reg)
    `OQ_ASSERT_IMPL(a_busy_no_out, clk, rst_n, state_reg != S_IDLE && state_reg != S_DONE,
                    !in_ready)
endmodule
